// ===== hdl/pna_pkg.sv =====
// Shared types, sizes and codes for the per-node average temperature alarm.
`timescale 1ns / 1ps

package pna_pkg;

  localparam int MAX_NODES  = 32;
  localparam int WINDOW     = 5;
  localparam int DATA_W     = 16;
  localparam int NODE_IW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NODE_CW    = $clog2(MAX_NODES + 1);
  localparam int CNT_W      = $clog2(WINDOW + 1);
  localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int RING_DEPTH = MAX_NODES * WINDOW;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SUM_W      = DATA_W + CNT_W;
  localparam int MAG_W      = SUM_W - 1;
  localparam int BND_W      = SUM_W + 1;
  localparam int ITER_W     = $clog2(MAG_W + 1);
  localparam int CFG_IW     = 4;

  localparam logic [CFG_IW-1:0] REG_HOT_LIMIT  = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] REG_COLD_LIMIT = CFG_IW'(1);

  localparam logic signed [DATA_W-1:0] HOT_RESET  = 16'sd300;
  localparam logic signed [DATA_W-1:0] COLD_RESET = 16'sd100;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_HOT  = 2'd1,
    EV_COLD = 2'd2,
    EV_DROP = 2'd3
  } event_code_t;

  typedef struct packed {
    logic [DATA_W-1:0]        node_ident;
    logic signed [DATA_W-1:0] temp_tenths;
  } reading_t;

  typedef struct packed {
    event_code_t              event_code;
    logic [DATA_W-1:0]        event_node;
    logic signed [DATA_W-1:0] average_tenths;
  } alarm_t;

  typedef struct packed {
    logic hot;
    logic cold;
  } alarm_flags_t;

endpackage

// ===== hdl/pna_div.sv =====
// Iterative signed divider: window sum over sample count, one quotient bit per cycle.
`timescale 1ns / 1ps

module pna_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [pna_pkg::SUM_W-1:0]   dividend,
  input  logic [pna_pkg::CNT_W-1:0]          divisor,
  output logic                               done,
  output logic signed [pna_pkg::DATA_W-1:0]  quotient
);

  logic                              busy;
  logic [pna_pkg::ITER_W-1:0]        iter;
  logic [pna_pkg::MAG_W-1:0]         mag;
  logic [pna_pkg::CNT_W-1:0]         rem;
  logic [pna_pkg::CNT_W-1:0]         dsr;
  logic                              neg;
  logic [pna_pkg::CNT_W:0]           trial;
  logic                              qbit;
  logic [pna_pkg::SUM_W-1:0]         abs_in;

  assign abs_in = (dividend < 0) ? pna_pkg::SUM_W'(-dividend) : pna_pkg::SUM_W'(dividend);
  assign trial  = {rem, mag[pna_pkg::MAG_W-1]};
  assign qbit   = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= pna_pkg::ITER_W'(pna_pkg::MAG_W);
      end else if (busy) begin
        iter <= iter - 1'b1;
        if (iter == pna_pkg::ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag <= abs_in[pna_pkg::MAG_W-1:0];
      neg <= (dividend < 0);
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= qbit ? pna_pkg::CNT_W'(trial - {1'b0, dsr}) : trial[pna_pkg::CNT_W-1:0];
      mag <= {mag[pna_pkg::MAG_W-2:0], qbit};
    end
  end

  assign quotient = neg ? pna_pkg::DATA_W'(-$signed({1'b0, mag}))
                        : pna_pkg::DATA_W'($signed({1'b0, mag}));

endmodule

// ===== hdl/pna_alarm.sv =====
// Threshold decision: compares window sum with limit times count and updates alarm flags.
`timescale 1ns / 1ps

module pna_alarm (
  input  logic signed [pna_pkg::SUM_W-1:0]  sum,
  input  logic [pna_pkg::CNT_W-1:0]         cnt,
  input  logic signed [pna_pkg::DATA_W-1:0] hot_limit,
  input  logic signed [pna_pkg::DATA_W-1:0] cold_limit,
  input  pna_pkg::alarm_flags_t             flags,
  output pna_pkg::event_code_t              code,
  output pna_pkg::alarm_flags_t             flags_next
);

  logic signed [pna_pkg::BND_W-1:0] cnt_s;
  logic signed [pna_pkg::BND_W-1:0] hot_bound;
  logic signed [pna_pkg::BND_W-1:0] cold_bound;
  logic signed [pna_pkg::BND_W-1:0] sum_s;

  assign cnt_s      = $signed(pna_pkg::BND_W'(cnt));
  assign sum_s      = pna_pkg::BND_W'(sum);
  assign hot_bound  = pna_pkg::BND_W'(hot_limit) * cnt_s;
  assign cold_bound = pna_pkg::BND_W'(cold_limit) * cnt_s;

  always_comb begin
    code       = pna_pkg::EV_NONE;
    flags_next = flags;
    priority if (sum_s > hot_bound && !flags.hot) begin
      code            = pna_pkg::EV_HOT;
      flags_next.hot  = 1'b1;
      flags_next.cold = 1'b0;
    end else if (sum_s < cold_bound && !flags.cold) begin
      code            = pna_pkg::EV_COLD;
      flags_next.hot  = 1'b0;
      flags_next.cold = 1'b1;
    end else if (sum_s >= cold_bound && sum_s <= hot_bound) begin
      flags_next.hot  = 1'b0;
      flags_next.cold = 1'b0;
    end
  end

endmodule

// ===== hdl/per_node_avg_temp_alarm.sv =====
// Top level: per-node moving average temperature alarm with search, sum and divide sequencer.
//
// Usage:
//   reading channel (reading_valid / reading_stall / reading) carries one
//   node id and temperature in tenths. An item is taken when valid is high
//   and stall is low; stall stays high while an item is in work.
//   alarm channel (alarm_valid / alarm_stall / alarm) returns exactly one
//   item per reading: event code, node id and truncated window average.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//   hot_limit (index 0) and cold_limit (index 1); cfg_ready is always high.
// Per reading: node search scans the table one entry a cycle, then the
//   write state stores the sample, the sum state adds the window from the
//   sample memory, the bit-serial divider forms the average and the finish
//   state loads the result; one reading is in work at a time.
// Reset clears the node count, per-node state and the result valid and loads
//   the limits with 300 and 100. A stalled result holds in its register;
//   the next reading is taken meanwhile and waits to load until it drains.
`timescale 1ns / 1ps

module per_node_avg_temp_alarm (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             reading_valid,
  output logic                             reading_stall,
  input  pna_pkg::reading_t                reading,
  output logic                             alarm_valid,
  input  logic                             alarm_stall,
  output pna_pkg::alarm_t                  alarm,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pna_pkg::CFG_IW-1:0]       cfg_index,
  input  logic [pna_pkg::DATA_W-1:0]       cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,
    S_WRITE  = 6'b000100,
    S_SUM    = 6'b001000,
    S_DIV    = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state;

  logic signed [pna_pkg::DATA_W-1:0] hot_limit;
  logic signed [pna_pkg::DATA_W-1:0] cold_limit;

  logic [pna_pkg::DATA_W-1:0]        node_table [pna_pkg::MAX_NODES];
  logic [pna_pkg::DATA_W-1:0]        table_q;
  logic signed [pna_pkg::DATA_W-1:0] sample_ring [pna_pkg::RING_DEPTH];
  logic signed [pna_pkg::DATA_W-1:0] ring_q;

  logic [pna_pkg::CNT_W-1:0]         fill_count [pna_pkg::MAX_NODES];
  logic [pna_pkg::SLOT_W-1:0]        write_slot [pna_pkg::MAX_NODES];
  pna_pkg::alarm_flags_t             flags      [pna_pkg::MAX_NODES];

  logic [pna_pkg::NODE_CW-1:0]       nodes_used;
  logic [pna_pkg::NODE_CW-1:0]       scan;
  logic                              cmp_pend;
  logic [pna_pkg::NODE_IW-1:0]       cmp_idx;
  logic [pna_pkg::NODE_IW-1:0]       node_idx;
  logic                              hit;

  pna_pkg::reading_t                 item;
  logic [pna_pkg::RING_AW-1:0]       ring_base;
  logic [pna_pkg::RING_AW-1:0]       base_next;
  logic [pna_pkg::CNT_W-1:0]         cnt;
  logic [pna_pkg::CNT_W-1:0]         fill_next;
  logic [pna_pkg::SLOT_W-1:0]        slot;
  logic [pna_pkg::SLOT_W-1:0]        slot_next;
  logic [pna_pkg::CNT_W-1:0]         k;
  logic                              sum_pend;
  logic signed [pna_pkg::SUM_W-1:0]  sum;
  logic                              sum_done;

  pna_pkg::event_code_t              res_code;
  logic signed [pna_pkg::DATA_W-1:0] res_avg;
  pna_pkg::event_code_t              alarm_code;
  pna_pkg::alarm_flags_t             flags_next;

  logic                              div_start;
  logic                              div_done;
  logic signed [pna_pkg::DATA_W-1:0] div_quo;
  logic                              out_free;

  assign reading_stall = (state != S_IDLE);
  assign cfg_ready     = 1'b1;

  assign hit       = cmp_pend && (table_q == item.node_ident);
  assign slot      = write_slot[node_idx];
  assign slot_next = (slot == pna_pkg::SLOT_W'(pna_pkg::WINDOW - 1)) ? '0 : slot + 1'b1;
  assign fill_next = (fill_count[node_idx] < pna_pkg::CNT_W'(pna_pkg::WINDOW))
                     ? fill_count[node_idx] + 1'b1 : fill_count[node_idx];
  assign base_next = pna_pkg::RING_AW'(node_idx * pna_pkg::WINDOW);
  assign sum_done  = (k == cnt) && !sum_pend;
  assign div_start = (state == S_SUM) && sum_done;
  assign out_free  = !alarm_valid || !alarm_stall;

  pna_alarm u_alarm (
    .sum        (sum),
    .cnt        (cnt),
    .hot_limit  (hot_limit),
    .cold_limit (cold_limit),
    .flags      (flags[node_idx]),
    .code       (alarm_code),
    .flags_next (flags_next)
  );

  pna_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (cnt),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hot_limit  <= pna_pkg::HOT_RESET;
      cold_limit <= pna_pkg::COLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == pna_pkg::REG_HOT_LIMIT) begin
        hot_limit <= $signed(cfg_data);
      end else if (cfg_index == pna_pkg::REG_COLD_LIMIT) begin
        cold_limit <= $signed(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    table_q <= node_table[scan[pna_pkg::NODE_IW-1:0]];
    if (state == S_SEARCH && !hit && scan == nodes_used &&
        nodes_used != pna_pkg::NODE_CW'(pna_pkg::MAX_NODES)) begin
      node_table[nodes_used[pna_pkg::NODE_IW-1:0]] <= item.node_ident;
    end
  end

  always_ff @(posedge clk) begin
    ring_q <= sample_ring[ring_base + pna_pkg::RING_AW'(k)];
    if (state == S_WRITE) begin
      sample_ring[base_next + pna_pkg::RING_AW'(slot)] <= item.temp_tenths;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      nodes_used  <= '0;
      cmp_pend    <= 1'b0;
      sum_pend    <= 1'b0;
      alarm_valid <= 1'b0;
      for (int i = 0; i < pna_pkg::MAX_NODES; i++) begin
        fill_count[i] <= '0;
        write_slot[i] <= '0;
        flags[i]      <= '0;
      end
    end else begin
      if (state == S_FINISH && out_free) begin
        alarm_valid <= 1'b1;
      end else if (!alarm_stall) begin
        alarm_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (reading_valid) begin
            item     <= reading;
            scan     <= '0;
            cmp_pend <= 1'b0;
            state    <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (hit) begin
            node_idx <= cmp_idx;
            cmp_pend <= 1'b0;
            state    <= S_WRITE;
          end else if (scan == nodes_used) begin
            cmp_pend <= 1'b0;
            if (nodes_used == pna_pkg::NODE_CW'(pna_pkg::MAX_NODES)) begin
              res_code <= pna_pkg::EV_DROP;
              res_avg  <= '0;
              state    <= S_FINISH;
            end else begin
              node_idx <= nodes_used[pna_pkg::NODE_IW-1:0];
              fill_count[nodes_used[pna_pkg::NODE_IW-1:0]] <= '0;
              write_slot[nodes_used[pna_pkg::NODE_IW-1:0]] <= '0;
              flags[nodes_used[pna_pkg::NODE_IW-1:0]]      <= '0;
              nodes_used <= nodes_used + 1'b1;
              state      <= S_WRITE;
            end
          end else begin
            cmp_pend <= 1'b1;
            cmp_idx  <= scan[pna_pkg::NODE_IW-1:0];
            scan     <= scan + 1'b1;
          end
        end
        S_WRITE: begin
          ring_base            <= base_next;
          write_slot[node_idx] <= slot_next;
          fill_count[node_idx] <= fill_next;
          cnt                  <= fill_next;
          k                    <= '0;
          sum_pend             <= 1'b0;
          sum                  <= '0;
          state                <= S_SUM;
        end
        S_SUM: begin
          if (sum_pend) begin
            sum <= sum + pna_pkg::SUM_W'(ring_q);
          end
          if (k != cnt) begin
            sum_pend <= 1'b1;
            k        <= k + 1'b1;
          end else begin
            sum_pend <= 1'b0;
            if (!sum_pend) begin
              res_code        <= alarm_code;
              flags[node_idx] <= flags_next;
              state           <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_avg <= div_quo;
            state   <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            alarm.event_code     <= res_code;
            alarm.event_node     <= item.node_ident;
            alarm.average_tenths <= res_avg;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
